// ===== rtl/core/icp_pkg.sv =====
// Shared types, symbol codes and lookup functions for the infix to postfix converter.
package icp_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int CHAR_W = 8;
    localparam int CODE_W = 3;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0] prio_t;

    localparam char_t CHAR_LPAREN = 8'h28;
    localparam char_t CHAR_RPAREN = 8'h29;
    localparam char_t CHAR_PLUS   = 8'h2B;
    localparam char_t CHAR_MINUS  = 8'h2D;
    localparam char_t CHAR_STAR   = 8'h2A;
    localparam char_t CHAR_SLASH  = 8'h2F;
    localparam char_t CHAR_ZERO   = 8'h30;
    localparam char_t CHAR_NINE   = 8'h39;
    localparam char_t CHAR_NUL    = 8'h00;

    localparam code_t CODE_LPAREN = 3'd0;
    localparam code_t CODE_PLUS   = 3'd1;
    localparam code_t CODE_MINUS  = 3'd2;
    localparam code_t CODE_MUL    = 3'd3;
    localparam code_t CODE_DIV    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_PUSH,
        S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_END,
        KIND_DIGIT,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_OP
    } kind_t;

    // Codes outside the symbol set read as an open parenthesis.
    function automatic code_t code_clean(input code_t c);
        code_t r;
        r = (c > CODE_DIV) ? CODE_LPAREN : c;
        return r;
    endfunction

    function automatic prio_t code_prio(input code_t c);
        prio_t p;
        unique case (c)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic char_t code_char(input code_t c);
        char_t ch;
        unique case (c)
            CODE_PLUS:  ch = CHAR_PLUS;
            CODE_MINUS: ch = CHAR_MINUS;
            CODE_MUL:   ch = CHAR_STAR;
            CODE_DIV:   ch = CHAR_SLASH;
            default:    ch = CHAR_LPAREN;
        endcase
        return ch;
    endfunction

    function automatic code_t op_code(input char_t ch);
        code_t c;
        unique case (ch)
            CHAR_PLUS:  c = CODE_PLUS;
            CHAR_MINUS: c = CODE_MINUS;
            CHAR_STAR:  c = CODE_MUL;
            CHAR_SLASH: c = CODE_DIV;
            default:    c = CODE_LPAREN;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/icp_stack_ram.sv =====
// Operator stack storage: one write port and one registered read port.
module icp_stack_ram #(
    parameter int DEPTH = icp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  icp_pkg::code_t                        wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output icp_pkg::code_t                        rd_data
);

    icp_pkg::code_t mem [DEPTH];
    icp_pkg::code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix to postfix converter.
//
// The input stream carries one character per word in s_axis_tdata; s_axis_tuser
// marks the end of an expression, and then the character is ignored. The output
// stream carries one postfix character per word in m_axis_tdata. On the closing
// word of an expression m_axis_tuser[0] (done) is high, the character is zero and
// m_axis_tuser[1] reports whether a push was dropped on a full stack since the
// previous done. m_axis_tlast is high on the last word caused by an input word.
// Operators wait on a stack in a synchronous RAM with a registered read port. An
// ignored character is dropped on acceptance; a digit is then sent on, and a '(' or
// an operator on an empty stack is pushed. An operator or ')' on a non-empty stack
// is accepted while the top is read; then each popped entry is handled in turn, the
// run stops at an entry that stays or at a matching '(' that is dropped, an operator
// is pushed, and a closing step releases the held last word (an operator that popped
// nothing skips it). An end word pops every stacked entry, releases the held last
// word and sends the done word. The single RAM read port allows one pop per cycle
// while the output register can take the held character. Each popped operator waits
// in a one-entry buffer until it is known whether another follows, so tlast is exact.
// Reset empties the stack and clears the overflow flag at once. A stalled receiver
// holds the output register and the converter waits; no word is lost or repeated.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = icp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tuser,   // [0] end_of_expr
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [0] done_res, [1] overflow
    output logic       m_axis_tlast    // last
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    icp_pkg::state_t state_reg, state_next;
    icp_pkg::kind_t  kind_reg, kind_next;
    icp_pkg::char_t  char_reg, char_next;
    icp_pkg::code_t  opcode_reg, opcode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            pend_valid_reg, pend_valid_next;
    icp_pkg::char_t  pend_char_reg, pend_char_next;
    logic            out_valid_reg, out_valid_next;
    icp_pkg::char_t  out_char_reg, out_char_next;
    logic            out_done_reg, out_done_next;
    logic            out_ovf_reg, out_ovf_next;
    logic            out_last_reg, out_last_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    icp_pkg::code_t   wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    icp_pkg::code_t   rd_data;

    logic             in_accept;
    icp_pkg::kind_t   in_kind;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_dec2;
    logic             stack_empty;
    logic             stack_full;
    logic             more_left;
    logic             slot_free;
    icp_pkg::code_t   top_code;
    logic             pop_req;
    logic             pop_fire;

    icp_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == icp_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_done_reg};
    assign m_axis_tlast  = out_last_reg;

    assign cnt_dec     = count_reg - CNT_W'(1);
    assign cnt_dec2    = count_reg - CNT_W'(2);
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign more_left   = (cnt_dec != '0);
    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign top_code    = icp_pkg::code_clean(rd_data);

    // Classify the incoming word.
    always_comb
    begin
        if (s_axis_tuser)
        begin
            in_kind = icp_pkg::KIND_END;
        end
        else if (s_axis_tdata >= icp_pkg::CHAR_ZERO && s_axis_tdata <= icp_pkg::CHAR_NINE)
        begin
            in_kind = icp_pkg::KIND_DIGIT;
        end
        else if (s_axis_tdata == icp_pkg::CHAR_LPAREN)
        begin
            in_kind = icp_pkg::KIND_OPEN;
        end
        else if (s_axis_tdata == icp_pkg::CHAR_RPAREN)
        begin
            in_kind = icp_pkg::KIND_CLOSE;
        end
        else if (s_axis_tdata == icp_pkg::CHAR_PLUS || s_axis_tdata == icp_pkg::CHAR_MINUS
                 || s_axis_tdata == icp_pkg::CHAR_STAR || s_axis_tdata == icp_pkg::CHAR_SLASH)
        begin
            in_kind = icp_pkg::KIND_OP;
        end
        else
        begin
            in_kind = icp_pkg::KIND_NONE;
        end
    end

    // Whether the entry on top of the stack leaves it, and whether it can leave now.
    // A pop moves any held character into the output register, so it needs a free slot
    // only when a character is already held.
    always_comb
    begin
        case (kind_reg)
            icp_pkg::KIND_END:   pop_req = 1'b1;
            icp_pkg::KIND_OP:    pop_req = icp_pkg::code_prio(top_code)
                                           >= icp_pkg::code_prio(opcode_reg);
            icp_pkg::KIND_CLOSE: pop_req = (top_code != icp_pkg::CODE_LPAREN);
            default:             pop_req = 1'b0;
        endcase
        pop_fire = (state_reg == icp_pkg::S_TOP) && pop_req
                   && (!pend_valid_reg || slot_free);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            icp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_kind)
                        icp_pkg::KIND_END:
                            state_next = stack_empty ? icp_pkg::S_FINAL : icp_pkg::S_TOP;
                        icp_pkg::KIND_DIGIT:
                            state_next = icp_pkg::S_FINAL;
                        icp_pkg::KIND_OPEN:
                            state_next = icp_pkg::S_PUSH;
                        icp_pkg::KIND_CLOSE:
                            state_next = stack_empty ? icp_pkg::S_IDLE : icp_pkg::S_TOP;
                        icp_pkg::KIND_OP:
                            state_next = stack_empty ? icp_pkg::S_PUSH : icp_pkg::S_TOP;
                        default:
                            state_next = icp_pkg::S_IDLE;
                    endcase
                end
            end
            icp_pkg::S_TOP:
            begin
                if (pop_req)
                begin
                    if (pop_fire && !more_left)
                    begin
                        state_next = (kind_reg == icp_pkg::KIND_OP) ? icp_pkg::S_PUSH
                                                                    : icp_pkg::S_FINAL;
                    end
                end
                else if (kind_reg == icp_pkg::KIND_OP)
                begin
                    state_next = icp_pkg::S_PUSH;
                end
                else
                begin
                    // A matching '(' ends the ')' run and is discarded.
                    state_next = icp_pkg::S_FINAL;
                end
            end
            icp_pkg::S_PUSH:
            begin
                state_next = pend_valid_reg ? icp_pkg::S_FINAL : icp_pkg::S_IDLE;
            end
            icp_pkg::S_FINAL:
            begin
                case (kind_reg)
                    icp_pkg::KIND_END:
                    begin
                        if (!pend_valid_reg && slot_free)
                        begin
                            state_next = icp_pkg::S_IDLE;
                        end
                    end
                    icp_pkg::KIND_DIGIT:
                    begin
                        if (slot_free)
                        begin
                            state_next = icp_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (!pend_valid_reg || slot_free)
                        begin
                            state_next = icp_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = icp_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, stack access and output register loading.
    always_comb
    begin
        kind_next       = kind_reg;
        char_next       = char_reg;
        opcode_next     = opcode_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_char_next   = out_char_reg;
        out_done_next   = out_done_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = opcode_reg;
        rd_en           = 1'b0;
        rd_addr         = cnt_dec[IDX_W-1:0];

        unique case (state_reg)
            icp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next   = in_kind;
                    char_next   = s_axis_tdata;
                    opcode_next = icp_pkg::op_code(s_axis_tdata);
                    rd_en       = !stack_empty;
                end
            end
            icp_pkg::S_TOP:
            begin
                if (pop_fire)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = pend_char_reg;
                        out_done_next  = 1'b0;
                        out_ovf_next   = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_char_next  = icp_pkg::code_char(top_code);
                    count_next      = cnt_dec;
                    rd_en           = more_left;
                    rd_addr         = cnt_dec2[IDX_W-1:0];
                end
                else if (!pop_req && kind_reg == icp_pkg::KIND_CLOSE)
                begin
                    count_next = cnt_dec;
                end
            end
            icp_pkg::S_PUSH:
            begin
                if (stack_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            icp_pkg::S_FINAL:
            begin
                case (kind_reg)
                    icp_pkg::KIND_END:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            if (pend_valid_reg)
                            begin
                                out_char_next   = pend_char_reg;
                                out_done_next   = 1'b0;
                                out_ovf_next    = 1'b0;
                                out_last_next   = 1'b0;
                                pend_valid_next = 1'b0;
                            end
                            else
                            begin
                                out_char_next = icp_pkg::CHAR_NUL;
                                out_done_next = 1'b1;
                                out_ovf_next  = ovf_reg;
                                out_last_next = 1'b1;
                                ovf_next      = 1'b0;
                            end
                        end
                    end
                    icp_pkg::KIND_DIGIT:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = char_reg;
                            out_done_next  = 1'b0;
                            out_ovf_next   = 1'b0;
                            out_last_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (pend_valid_reg && slot_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_char_next   = pend_char_reg;
                            out_done_next   = 1'b0;
                            out_ovf_next    = 1'b0;
                            out_last_next   = 1'b1;
                            pend_valid_next = 1'b0;
                        end
                    end
                endcase
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= icp_pkg::S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        char_reg      <= char_next;
        opcode_reg    <= opcode_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_done_reg  <= out_done_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== dv/infix_to_postfix_converter_tb.sv =====
// Self-checking testbench for the infix to postfix converter stream block.
module infix_to_postfix_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_STACK_DEPTH = icp_pkg::DEFAULT_STACK_DEPTH;
    // No word may be accepted on either side for this many cycles in a row.
    // The slowest correct case is a long receiver hold-off or a full flush of 17
    // words under random stalls, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to let pass once every expected word is in. This covers the time
    // the block may still spend on words that emit nothing.
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS   = 260;

    // One expected output word: character, done, overflow and last flags.
    typedef struct packed {
        icp_pkg::char_t ch;
        logic           done;
        logic           ovf;
        logic           last;
    } postfix_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
    logic       s_axis_tuser = 1'b0;    // [0] end_of_expr
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic [1:0] m_axis_tuser;           // [0] done_res, [1] overflow
    logic       m_axis_tlast;           // last

    // Predicted postfix words, oldest first, and the words of the item at hand.
    postfix_word_t postfix_q[$];
    postfix_word_t burst_q[$];
    postfix_word_t got_word;
    postfix_word_t want_word;

    // Private copy of the operator stack.
    icp_pkg::code_t op_stack_model [TB_STACK_DEPTH];
    int             stack_fill = 0;
    bit             overflow_flag = 1'b0;

    // Infix text of the next random expression.
    icp_pkg::char_t infix_q[$];

    int mismatch_count = 0;
    int stall_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_len = 0;

    always #4 clk = ~clk;

    infix_to_postfix_converter #(
        .STACK_DEPTH(TB_STACK_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The stack only ever holds the five symbol codes, so ordering gives priority.
    function automatic int sym_prio(input icp_pkg::code_t c);
        return (c >= icp_pkg::CODE_MUL) ? 2 : ((c >= icp_pkg::CODE_PLUS) ? 1 : 0);
    endfunction

    function automatic icp_pkg::char_t sym_char(input icp_pkg::code_t c);
        icp_pkg::char_t ch;
        case (c)
            icp_pkg::CODE_PLUS:  ch = icp_pkg::CHAR_PLUS;
            icp_pkg::CODE_MINUS: ch = icp_pkg::CHAR_MINUS;
            icp_pkg::CODE_MUL:   ch = icp_pkg::CHAR_STAR;
            icp_pkg::CODE_DIV:   ch = icp_pkg::CHAR_SLASH;
            default:             ch = icp_pkg::CHAR_LPAREN;
        endcase
        return ch;
    endfunction

    function automatic void emit_word(input icp_pkg::char_t ch, input logic done,
                                      input logic ovf);
        postfix_word_t w;
        w.ch   = ch;
        w.done = done;
        w.ovf  = ovf;
        w.last = 1'b0;
        burst_q.push_back(w);
    endfunction

    // Pops the top entry and emits its character.
    function automatic void pop_and_emit();
        emit_word(sym_char(op_stack_model[stack_fill-1]), 1'b0, 1'b0);
        stack_fill--;
    endfunction

    // A push onto a full stack is lost and only leaves the sticky flag behind.
    function automatic void push_symbol(input icp_pkg::code_t c);
        if (stack_fill >= TB_STACK_DEPTH)
        begin
            overflow_flag = 1'b1;
        end
        else
        begin
            op_stack_model[stack_fill] = c;
            stack_fill++;
        end
    endfunction

    // Works out the postfix words caused by one accepted input word and queues them.
    function automatic void predict_postfix(input icp_pkg::char_t ch, input bit eoe);
        icp_pkg::code_t oc;
        postfix_word_t  w;
        burst_q.delete();
        case (ch)
            icp_pkg::CHAR_PLUS:  oc = icp_pkg::CODE_PLUS;
            icp_pkg::CHAR_MINUS: oc = icp_pkg::CODE_MINUS;
            icp_pkg::CHAR_STAR:  oc = icp_pkg::CODE_MUL;
            icp_pkg::CHAR_SLASH: oc = icp_pkg::CODE_DIV;
            default:             oc = icp_pkg::CODE_LPAREN;
        endcase
        if (eoe)
        begin
            // Flush top first; a leftover '(' comes out as itself.
            while (stack_fill > 0) pop_and_emit();
            emit_word(icp_pkg::CHAR_NUL, 1'b1, overflow_flag);
            overflow_flag = 1'b0;
        end
        else if (ch >= icp_pkg::CHAR_ZERO && ch <= icp_pkg::CHAR_NINE)
        begin
            emit_word(ch, 1'b0, 1'b0);
        end
        else if (ch == icp_pkg::CHAR_LPAREN)
        begin
            push_symbol(icp_pkg::CODE_LPAREN);
        end
        else if (ch == icp_pkg::CHAR_RPAREN)
        begin
            // Without a matching '(' this simply empties the stack.
            while (stack_fill > 0 && op_stack_model[stack_fill-1] != icp_pkg::CODE_LPAREN)
                pop_and_emit();
            if (stack_fill > 0) stack_fill--;
        end
        else if (oc != icp_pkg::CODE_LPAREN)
        begin
            while (stack_fill > 0 && sym_prio(op_stack_model[stack_fill-1]) >= sym_prio(oc))
                pop_and_emit();
            push_symbol(oc);
        end
        if (burst_q.size() > 0)
        begin
            w = burst_q.pop_back();
            w.last = 1'b1;
            burst_q.push_back(w);
        end
        foreach (burst_q[i]) postfix_q.push_back(burst_q[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic icp_pkg::char_t random_operator();
        icp_pkg::char_t ch;
        case ($urandom_range(0, 3))
            0:       ch = icp_pkg::CHAR_PLUS;
            1:       ch = icp_pkg::CHAR_MINUS;
            2:       ch = icp_pkg::CHAR_STAR;
            default: ch = icp_pkg::CHAR_SLASH;
        endcase
        return ch;
    endfunction

    // Builds one infix expression. Shape 0 is well formed, shape 1 is broken
    // (stray parentheses or a dangling operator), shape 2 nests deeply and can
    // run past the stack depth. A few random bytes are mixed in as noise.
    function automatic void build_infix(input int shape);
        int operands;
        int open_cnt;
        int opens;
        int closes;
        infix_q.delete();
        operands = $urandom_range(1, 6);
        open_cnt = 0;
        for (int i = 0; i < operands; i++)
        begin
            if (shape == 2) opens = $urandom_range(0, 6);
            else opens = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (opens) infix_q.push_back(icp_pkg::CHAR_LPAREN);
            open_cnt += opens;
            infix_q.push_back(icp_pkg::char_t'(icp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            if (open_cnt > 0 && $urandom_range(0, 2) == 0)
            begin
                closes = $urandom_range(1, open_cnt);
                repeat (closes) infix_q.push_back(icp_pkg::CHAR_RPAREN);
                open_cnt -= closes;
            end
            if (i < operands - 1) infix_q.push_back(random_operator());
            if ($urandom_range(0, 99) < 8)
                infix_q.push_back(icp_pkg::char_t'($urandom_range(0, 255)));
        end
        if (shape == 1)
        begin
            case ($urandom_range(0, 2))
                0:       infix_q.insert($urandom_range(0, infix_q.size()),
                                        icp_pkg::CHAR_RPAREN);
                1:       infix_q.push_back(random_operator());
                default: infix_q.insert($urandom_range(0, infix_q.size()),
                                        icp_pkg::CHAR_LPAREN);
            endcase
            if ($urandom_range(0, 1) == 0) open_cnt = 0;
        end
        repeat (open_cnt) infix_q.push_back(icp_pkg::CHAR_RPAREN);
    endfunction

    // Offers one input word, after a random number of idle cycles, and waits
    // until it is accepted. Valid stays high between back-to-back words.
    task automatic send_word(input icp_pkg::char_t ch, input bit eoe);
        while (tx_idle_on && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= ch;
        s_axis_tuser  <= eoe;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
        predict_postfix(ch, eoe);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_word(icp_pkg::char_t'(s[i]), 1'b0);
    endtask

    // Sends the built expression and closes it with an end word.
    task automatic send_infix(output int words);
        foreach (infix_q[i]) send_word(infix_q[i], 1'b0);
        send_word(icp_pkg::char_t'($urandom_range(0, 255)), 1'b1);
        words = infix_q.size() + 1;
    endtask

    // The sender stops until every predicted word has come out.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Operator priorities, parentheses, unmatched open and close, ignored bytes
    // at both ends of the range, and end words with odd characters on them.
    task automatic test_directed();
        send_string("1+2*3");
        send_word(icp_pkg::CHAR_NUL, 1'b1);
        send_string("(9-0)/8");
        send_word(8'h7F, 1'b1);
        send_string("4*5)");
        send_word(8'hFF, 1'b1);
        send_string("((");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(icp_pkg::CHAR_MINUS, 1'b0);
        send_word(8'h80, 1'b1);
    endtask

    // Fills the stack with '(' so that the next pushes are dropped; the flush
    // then gives the largest burst, and a second end shows the flag cleared.
    task automatic test_overflow();
        repeat (TB_STACK_DEPTH) send_word(icp_pkg::CHAR_LPAREN, 1'b0);
        send_word(icp_pkg::CHAR_PLUS, 1'b0);
        send_word(icp_pkg::CHAR_LPAREN, 1'b0);
        send_word(icp_pkg::CHAR_NUL, 1'b1);
        send_word(icp_pkg::CHAR_NUL, 1'b1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the block fills up and stalls its input.
    task automatic test_backpressure();
        int sent;
        int n;
        sent = 0;
        rx_hold_len = RX_HOLD_CYCLES;
        while (sent < 40)
        begin
            build_infix(0);
            send_infix(n);
            sent += n;
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_no_idle();
        int sent;
        int n;
        sent = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (sent < 60)
        begin
            build_infix((sent == 0) ? 2 : 0);
            send_infix(n);
            sent += n;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Mostly well-formed expressions with random content, the rest broken or
    // deeply nested, at times past the stack depth.
    task automatic test_random();
        int sent;
        int n;
        int r;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            build_infix((r < 70) ? 0 : ((r < 88) ? 1 : 2));
            send_infix(n);
            sent += n;
            if ($urandom_range(0, 29) == 0) wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drives tready: random idling, an occasional long hold-off requested by a
    // test, or always ready during the no-idle stretch.
    initial
    begin : rx_driver
        int held;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                held = rx_hold_len;
                rx_hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            else if (!rx_idle_on)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Each accepted output word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_word = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
            if (postfix_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word char=%02h done=%0b ovf=%0b last=%0b",
                    got_word.ch, got_word.done, got_word.ovf, got_word.last));
            end
            else
            begin
                want_word = postfix_q.pop_front();
                if (got_word !== want_word)
                    report_mismatch($sformatf(
                        "got char=%02h done=%0b ovf=%0b last=%0b, want %02h %0b %0b %0b",
                        got_word.ch, got_word.done, got_word.ovf, got_word.last,
                        want_word.ch, want_word.done, want_word.ovf, want_word.last));
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_for_drain();
        test_overflow();
        wait_for_drain();
        test_backpressure();
        wait_for_drain();
        test_no_idle();
        wait_for_drain();
        test_random();
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && postfix_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== infix_to_postfix_converter.f =====
rtl/core/icp_pkg.sv
rtl/core/icp_stack_ram.sv
rtl/core/infix_to_postfix_converter.sv
dv/infix_to_postfix_converter_tb.sv
